@@ hdl/rtpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtpt_pkg;

  localparam int DEF_FRAC_BITS = 16;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [32:0] FOV_TO_RAD = 33'sd2398309738;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    CFG_ROTATION = 3'd0,
    CFG_SHIFT_X  = 3'd1,
    CFG_SHIFT_Y  = 3'd2,
    CFG_SHIFT_Z  = 3'd3,
    CFG_SCREEN   = 3'd4,
    CFG_CLIP     = 3'd5,
    CFG_FOV      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] rotation;
    logic [31:0] shift_x;
    logic [31:0] shift_y;
    logic [31:0] shift_z;
    logic [31:0] screen;
    logic [63:0] clip;
    logic [15:0] fov;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [3:0]        idx;
    logic signed [31:0] data;
  } mat_wr_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -66'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0: r = 36'sd843314857;
      5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043837;
      5'd3: r = 36'sd133525159;
      5'd4: r = 36'sd67021687;
      5'd5: r = 36'sd33543516;
      5'd6: r = 36'sd16775851;
      5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194283;
      5'd9: r = 36'sd2097149;
      default: r = 36'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rtpt_build.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtpt_build #(
  parameter int FRAC_BITS = rtpt_pkg::DEF_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire rtpt_pkg::cfg_t   cfg,
  output logic                  busy,
  output rtpt_pkg::mat_wr_t     mat_wr
);
  import rtpt_pkg::*;

  localparam int CW = $clog2(64 + FRAC_BITS + 1);
  localparam logic [CW-1:0] TOP_FRAC = CW'(64 + FRAC_BITS);
  localparam logic [CW-1:0] TOP_INT = CW'(64);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_FOVMUL  = 14'b00000000000010,
    ST_FOVSAVE = 14'b00000000000100,
    ST_LOAD    = 14'b00000000001000,
    ST_CORDIC  = 14'b00000000010000,
    ST_RMUL    = 14'b00000000100000,
    ST_RACC    = 14'b00000001000000,
    ST_NUM     = 14'b00000010000000,
    ST_DEN     = 14'b00000100000000,
    ST_DLOAD   = 14'b00001000000000,
    ST_DIV     = 14'b00010000000000,
    ST_DDONE   = 14'b00100000000000,
    ST_EMUL    = 14'b01000000000000,
    ST_EACC    = 14'b10000000000000
  } state_t;

  function automatic logic signed [32:0] rot_elem(input logic [1:0] axis, input logic [1:0] r,
                                                  input logic [1:0] c,
                                                  input logic signed [32:0] cv,
                                                  input logic signed [32:0] sv);
    logic signed [32:0] e;
    e = '0;
    case (axis)
      2'd0: begin
        case ({r, c})
          4'b0000: e = ONE_Q30;
          4'b0101: e = cv;
          4'b0110: e = -sv;
          4'b1001: e = sv;
          4'b1010: e = cv;
          default: e = '0;
        endcase
      end
      2'd1: begin
        case ({r, c})
          4'b0000: e = cv;
          4'b0010: e = -sv;
          4'b0101: e = ONE_Q30;
          4'b1000: e = sv;
          4'b1010: e = cv;
          default: e = '0;
        endcase
      end
      default: begin
        case ({r, c})
          4'b0000: e = cv;
          4'b0001: e = -sv;
          4'b0100: e = sv;
          4'b0101: e = cv;
          4'b1010: e = ONE_Q30;
          default: e = '0;
        endcase
      end
    endcase
    return e;
  endfunction

  state_t state;
  logic [1:0] ax;
  logic [4:0] it;
  logic signed [35:0] th;
  logic signed [33:0] cx, cy;
  logic flip;
  logic signed [32:0] cs_c [4];
  logic signed [32:0] cs_s [4];
  logic [31:0] fov_th;
  logic phase;
  logic [1:0] rr, rc, rk;
  logic signed [63:0] acc;
  logic signed [32:0] rq [9];
  logic signed [32:0] rot [9];
  logic [1:0] dn;
  logic [63:0] nm, dm, rem;
  logic [43:0] q;
  logic big;
  logic [CW-1:0] dcnt;
  logic signed [31:0] coef [4];
  logic [3:0] en;
  logic signed [65:0] mp;

  logic signed [32:0] ma, mb;
  logic [15:0] ang;
  logic signed [35:0] th0, th_fold;
  logic flip0;
  logic signed [35:0] cord_a, th_nx;
  logic signed [33:0] x_nx, y_nx;
  logic signed [32:0] cf, sf, magcf, magsf;
  logic signed [33:0] nr34, fr34, nmf, dnf;
  logic signed [32:0] fr33, nr33, magfr, magnr;
  logic [33:0] absn, absd;
  logic neg_d;
  logic [63:0] num_sel, den_sel;
  logic [CW-1:0] dsh, bidx;
  logic dbit, sbit;
  logic [63:0] r2;
  logic [44:0] qp1;
  logic [43:0] qm;
  logic signed [31:0] qres;
  logic signed [63:0] rsum, rrnd;
  logic [3:0] rwi, ri;
  logic [1:0] er, ek, src;
  logic signed [32:0] tsel;
  logic signed [65:0] e_rnd;
  logic signed [31:0] e_val;

  assign busy = (state != ST_IDLE);

  always_comb begin
    case (ax)
      2'd0: ang = cfg.rotation[47:32];
      2'd1: ang = cfg.rotation[31:16];
      default: ang = cfg.rotation[15:0];
    endcase
    if (ax == 2'd3) begin
      th0 = {4'b0, fov_th};
    end else begin
      th0 = {{3{ang[15]}}, ang, 17'b0};
    end
    flip0 = 1'b0;
    th_fold = th0;
    if (th0 > HALF_PI_Q30) begin
      th_fold = th0 - PI_Q30;
      flip0 = 1'b1;
    end else if (th0 < -HALF_PI_Q30) begin
      th_fold = th0 + PI_Q30;
      flip0 = 1'b1;
    end
  end

  always_comb begin
    cord_a = atan_q30(it);
    if (!th[35]) begin
      x_nx = cx - (cy >>> it);
      y_nx = cy + (cx >>> it);
      th_nx = th - cord_a;
    end else begin
      x_nx = cx + (cy >>> it);
      y_nx = cy - (cx >>> it);
      th_nx = th + cord_a;
    end
  end

  always_comb begin
    cf = cs_c[3];
    sf = cs_s[3];
    magcf = cf[32] ? -cf : cf;
    magsf = sf[32] ? -sf : sf;
    nr34 = {{2{cfg.clip[63]}}, cfg.clip[63:32]};
    fr34 = {{2{cfg.clip[31]}}, cfg.clip[31:0]};
    nr33 = nr34[32:0];
    fr33 = fr34[32:0];
    magnr = nr33[32] ? -nr33 : nr33;
    magfr = fr33[32] ? -fr33 : fr33;
    nmf = -nr34 - fr34;
    dnf = nr34 - fr34;
    absn = nmf[33] ? 34'(-nmf) : 34'(nmf);
    absd = dnf[33] ? 34'(-dnf) : 34'(dnf);
    case (dn)
      2'd0: begin
        num_sel = mp[63:0];
        den_sel = mp[63:0];
        neg_d = cf[32] ^ sf[32];
      end
      2'd1: begin
        num_sel = {31'b0, magcf};
        den_sel = {31'b0, magsf};
        neg_d = cf[32] ^ sf[32];
      end
      2'd2: begin
        num_sel = {30'b0, absn};
        den_sel = {30'b0, absd};
        neg_d = nmf[33] ^ dnf[33];
      end
      default: begin
        num_sel = {mp[62:0], 1'b0};
        den_sel = {30'b0, absd};
        neg_d = cfg.clip[31] ^ cfg.clip[63] ^ dnf[33];
      end
    endcase
  end

  always_comb begin
    dsh = (dn == 2'd3) ? CW'(0) : CW'(FRAC_BITS);
    bidx = dcnt - dsh - CW'(1);
    dbit = (dcnt > dsh) ? nm[bidx[5:0]] : 1'b0;
    r2 = {rem[62:0], dbit};
    sbit = (r2 >= dm);
    qp1 = {1'b0, q} + 45'd1;
    qm = big ? 44'h100_0000_0000 : qp1[44:1];
    if (neg_d) begin
      qres = (qm > 44'd2147483648) ? S32_MIN : 32'(-qm);
    end else begin
      qres = (qm > 44'd2147483647) ? S32_MAX : qm[31:0];
    end
  end

  always_comb begin
    rsum = acc + $signed(mp[63:0]);
    rrnd = (rsum + (64'sd1 <<< 29)) >>> 30;
    rwi = {2'b0, rr} * 4'd3 + {2'b0, rc};
    er = en[3:2];
    ek = en[1:0];
    src = (er == 2'd3) ? 2'd2 : er;
    ri = {2'b0, src} * 4'd3 + {2'b0, ek};
    case (src)
      2'd0: tsel = {cfg.shift_x[31], cfg.shift_x};
      2'd1: tsel = {cfg.shift_y[31], cfg.shift_y};
      default: tsel = {cfg.shift_z[31], cfg.shift_z};
    endcase
    if (ek == 2'd3) begin
      e_rnd = ((mp + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) +
              ((er == 2'd2) ? (66'sd1 <<< FRAC_BITS) : 66'sd0);
    end else begin
      e_rnd = (mp + (66'sd1 <<< 29)) >>> 30;
    end
    e_val = sat32(e_rnd);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_FOVMUL: begin
        ma = {17'b0, cfg.fov};
        mb = FOV_TO_RAD;
      end
      ST_RMUL: begin
        if (phase) begin
          ma = rot_elem(2'd2, rr, rk, cs_c[2], cs_s[2]);
          mb = rq[{2'b0, rk} * 4'd3 + {2'b0, rc}];
        end else begin
          ma = rot_elem(2'd1, rr, rk, cs_c[1], cs_s[1]);
          mb = rot_elem(2'd0, rk, rc, cs_c[0], cs_s[0]);
        end
      end
      ST_NUM: begin
        ma = (dn == 2'd3) ? magfr : magcf;
        mb = (dn == 2'd3) ? magnr : {17'b0, cfg.screen[15:0]};
      end
      ST_DEN: begin
        ma = magsf;
        mb = {17'b0, cfg.screen[31:16]};
      end
      ST_EMUL: begin
        ma = {coef[er][31], coef[er]};
        mb = (ek == 2'd3) ? tsel : rot[ri];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    mat_wr.we = (state == ST_EACC);
    mat_wr.idx = en;
    mat_wr.data = e_val;
  end

  always_ff @(posedge clk) begin
    mp <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_FOVMUL;
          end
        end
        ST_FOVMUL: begin
          state <= ST_FOVSAVE;
        end
        ST_FOVSAVE: begin
          fov_th <= 32'((mp[47:0] + 48'd32768) >> 16);
          ax <= 2'd0;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          th <= th_fold;
          flip <= flip0;
          cx <= CORDIC_GAIN;
          cy <= '0;
          it <= '0;
          state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          cx <= x_nx;
          cy <= y_nx;
          th <= th_nx;
          it <= it + 5'd1;
          if (it == 5'd29) begin
            cs_c[ax] <= flip ? 33'(-x_nx) : 33'(x_nx);
            cs_s[ax] <= flip ? 33'(-y_nx) : 33'(y_nx);
            ax <= ax + 2'd1;
            if (ax == 2'd3) begin
              phase <= 1'b0;
              rr <= '0;
              rc <= '0;
              rk <= '0;
              acc <= '0;
              state <= ST_RMUL;
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_RMUL: begin
          state <= ST_RACC;
        end
        ST_RACC: begin
          state <= ST_RMUL;
          if (rk == 2'd2) begin
            if (phase) begin
              rot[rwi] <= rrnd[32:0];
            end else begin
              rq[rwi] <= rrnd[32:0];
            end
            acc <= '0;
            rk <= '0;
            if (rc == 2'd2) begin
              rc <= '0;
              if (rr == 2'd2) begin
                rr <= '0;
                if (phase) begin
                  dn <= '0;
                  state <= ST_NUM;
                end else begin
                  phase <= 1'b1;
                end
              end else begin
                rr <= rr + 2'd1;
              end
            end else begin
              rc <= rc + 2'd1;
            end
          end else begin
            acc <= rsum;
            rk <= rk + 2'd1;
          end
        end
        ST_NUM: begin
          state <= ST_DEN;
        end
        ST_DEN: begin
          nm <= num_sel;
          state <= ST_DLOAD;
        end
        ST_DLOAD: begin
          dm <= den_sel;
          rem <= '0;
          q <= '0;
          big <= 1'b0;
          dcnt <= (dn == 2'd3) ? TOP_INT : TOP_FRAC;
          if (den_sel == 64'd0) begin
            coef[dn] <= neg_d ? S32_MIN : S32_MAX;
            dn <= dn + 2'd1;
            en <= '0;
            state <= (dn == 2'd3) ? ST_EMUL : ST_NUM;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= sbit ? (r2 - dm) : r2;
          big <= big | (q[43:40] != 4'd0);
          q <= {q[42:0], sbit};
          dcnt <= dcnt - CW'(1);
          if (dcnt == CW'(0)) begin
            state <= ST_DDONE;
          end
        end
        ST_DDONE: begin
          coef[dn] <= qres;
          dn <= dn + 2'd1;
          en <= '0;
          state <= (dn == 2'd3) ? ST_EMUL : ST_NUM;
        end
        ST_EMUL: begin
          state <= ST_EACC;
        end
        ST_EACC: begin
          en <= en + 4'd1;
          state <= (en == 4'd15) ? ST_IDLE : ST_EMUL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/rtpt_mvp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtpt_mvp #(
  parameter int FRAC_BITS = rtpt_pkg::DEF_FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rtpt_pkg::mat_wr_t   mat_wr,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_x,
  input  wire logic signed [31:0]  in_y,
  input  wire logic signed [31:0]  in_z,
  input  wire logic signed [31:0]  in_w,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic signed [31:0]       out_w
);
  import rtpt_pkg::*;

  localparam int HW = 66 - FRAC_BITS;
  localparam int LW = FRAC_BITS + 3;

  logic signed [31:0] mat [16];
  logic signed [31:0] vin [4];
  logic signed [63:0] prod [16];
  logic signed [HW-1:0] hi [4];
  logic [LW-1:0] lo [4];
  logic signed [HW-1:0] hi_next [4];
  logic [LW-1:0] lo_next [4];
  logic signed [31:0] res_next [4];
  logic signed [31:0] res [4];
  logic v0, v1, v2;
  logic go0, go1, go2, go3;

  assign go3 = !out_valid || out_ready;
  assign go2 = !v2 || go3;
  assign go1 = !v1 || go2;
  assign go0 = !v0 || go1;
  assign in_ready = go0;

  always_ff @(posedge clk) begin
    if (mat_wr.we) begin
      mat[mat_wr.idx] <= mat_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go0) v0 <= in_valid;
      if (go1) v1 <= v0;
      if (go2) v2 <= v1;
      if (go3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (go0 && in_valid) begin
      vin[0] <= in_x;
      vin[1] <= in_y;
      vin[2] <= in_z;
      vin[3] <= in_w;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_prod
    always_ff @(posedge clk) begin
      if (go1) begin
        prod[i] <= mat[i] * vin[i % 4];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      hi_next[r] = '0;
      lo_next[r] = '0;
      for (int c = 0; c < 4; c++) begin
        hi_next[r] = hi_next[r] + HW'(prod[r * 4 + c] >>> FRAC_BITS);
        lo_next[r] = lo_next[r] + LW'(prod[r * 4 + c][FRAC_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      for (int r = 0; r < 4; r++) begin
        hi[r] <= hi_next[r];
        lo[r] <= lo_next[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      res_next[r] = sat32(66'(hi[r]) +
                          66'((lo[r] + LW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      for (int r = 0; r < 4; r++) begin
        res[r] <= res_next[r];
      end
    end
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

`default_nettype wire

@@ hdl/rotate_translate_project_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Word
// cfg      cfg_valid/cfg_ready    cfg_index (register number), cfg_data
// in       in_valid/in_ready      in_x, in_y, in_z, in_w (one column)
// out      out_valid/out_ready    out_x, out_y, out_z, out_w
//
// One word is taken per cycle while in_ready is high, and its result is presented once
// it has passed the vin, prod, hi/lo and res registers. After reset and after every
// register write the matrix is rebuilt by a sequencer with one shared multiplier;
// in_ready and cfg_ready stay low meanwhile.
// Back pressure on out stalls the pipeline stage by stage without loss.

module rotate_translate_project_transform #(
  parameter int FRAC_BITS = rtpt_pkg::DEF_FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_x,
  input  wire logic signed [31:0]  in_y,
  input  wire logic signed [31:0]  in_z,
  input  wire logic signed [31:0]  in_w,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic signed [31:0]       out_w
);
  import rtpt_pkg::*;

  cfg_t cfg;
  logic stale;
  logic busy;
  logic start;
  logic gate;
  logic cfg_hit;
  logic mvp_ready;
  mat_wr_t mat_wr;

  assign start = stale && !busy;
  assign gate = !stale && !busy;
  assign cfg_ready = !busy && !stale;
  assign cfg_hit = cfg_valid && cfg_ready && (cfg_index <= CFG_FOV);
  assign in_ready = gate && mvp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation <= '0;
      cfg.shift_x <= '0;
      cfg.shift_y <= '0;
      cfg.shift_z <= '0;
      cfg.screen <= 32'd41943520;
      cfg.clip <= 64'd281474983264256;
      cfg.fov <= 16'd11520;
      stale <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROTATION: cfg.rotation <= cfg_data[47:0];
          CFG_SHIFT_X: cfg.shift_x <= cfg_data[31:0];
          CFG_SHIFT_Y: cfg.shift_y <= cfg_data[31:0];
          CFG_SHIFT_Z: cfg.shift_z <= cfg_data[31:0];
          CFG_SCREEN: cfg.screen <= cfg_data[31:0];
          CFG_CLIP: cfg.clip <= cfg_data;
          CFG_FOV: cfg.fov <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        stale <= 1'b1;
      end else if (start) begin
        stale <= 1'b0;
      end
    end
  end

  rtpt_build #(
    .FRAC_BITS(FRAC_BITS)
  ) u_build (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cfg(cfg),
    .busy(busy),
    .mat_wr(mat_wr)
  );

  rtpt_mvp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mvp (
    .clk(clk),
    .rst(rst),
    .mat_wr(mat_wr),
    .in_valid(in_valid && gate),
    .in_ready(mvp_ready),
    .in_x(in_x),
    .in_y(in_y),
    .in_z(in_z),
    .in_w(in_w),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_w(out_w)
  );

  a_no_input_while_building: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (!busy && !stale))
    else $error("Input word taken while the matrix is not current.");

  a_write_triggers_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (stale && !busy))
    else $error("Register write did not schedule a rebuild.");

  a_matrix_written_in_build: assert property (@(posedge clk) disable iff (rst)
    mat_wr.we |-> busy)
    else $error("Matrix entry written outside a rebuild.");

endmodule

`default_nettype wire
